// File: src/stbs_pkg.sv
package stbs_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int KEY_CHARS   = 8;
    localparam int KEY_W       = 64;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    // worst case probe count over a full table
    localparam int PROBES      = IDX_W + 1;
    localparam int LATENCY     = PROBES + 1;

    localparam logic [CNT_W-1:0] COUNT_RESET = CNT_W'(26);
    localparam logic [CNT_W-1:0] COUNT_MAX   = CNT_W'(TABLE_DEPTH);

    localparam logic ACT_WRITE  = 1'b0;
    localparam logic ACT_SEARCH = 1'b1;

    typedef struct packed {
        logic              valid;
        logic              search;
        logic [IDX_W-1:0]  idx;
        logic [KEY_W-1:0]  key;
        logic [CNT_W-1:0]  lo;
        logic [CNT_W-1:0]  hi1;    // exclusive upper bound
        logic              found;
        logic [IDX_W-1:0]  match;
    } item_t;

    // fold A-Z to lower case, blank everything from the first zero byte
    function automatic logic [KEY_W-1:0] norm_key(input logic [KEY_W-1:0] w);
        logic [KEY_W-1:0] r;
        logic             ended;
        logic [7:0]       c;
        r     = '0;
        ended = 1'b0;
        for (int i = 0; i < 8; i++)
        begin
            c = w[KEY_W-1-8*i -: 8];
            if (i >= KEY_CHARS || c == 8'h00)
                ended = 1'b1;
            if (ended)
                c = 8'h00;
            else if (c >= 8'h41 && c <= 8'h5A)
                c = c + 8'h20;
            r[KEY_W-1-8*i -: 8] = c;
        end
        return r;
    endfunction

endpackage

// File: src/stbs_ram.sv
module stbs_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: src/stbs_probe.sv
module stbs_probe (
    input  logic            clk,
    input  logic            rst_n,
    input  stbs_pkg::item_t in_item,
    output stbs_pkg::item_t out_item
);

    logic                          valid_reg;
    stbs_pkg::item_t               item_reg;
    logic [stbs_pkg::IDX_W-1:0]    mid;
    logic [stbs_pkg::IDX_W-1:0]    mid_reg;
    logic [stbs_pkg::CNT_W:0]      sum;
    logic [stbs_pkg::KEY_W-1:0]    probe;
    logic                          active;

    // floor((lo + hi) / 2) with hi = hi1 - 1; only meaningful while lo < hi1
    assign sum = {1'b0, in_item.lo} + {1'b0, in_item.hi1} - (stbs_pkg::CNT_W+1)'(1);
    assign mid = sum[stbs_pkg::CNT_W-1:1];

    // this stage's copy of the table; writes reach it in item order
    stbs_ram #(
        .WIDTH (stbs_pkg::KEY_W),
        .DEPTH (stbs_pkg::TABLE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (in_item.valid && in_item.search == stbs_pkg::ACT_WRITE),
        .waddr (in_item.idx),
        .wdata (in_item.key),
        .raddr (mid),
        .rdata (probe)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_item.valid;
    end

    always_ff @(posedge clk)
    begin
        item_reg <= in_item;
        mid_reg  <= mid;
    end

    assign active = item_reg.search == stbs_pkg::ACT_SEARCH && !item_reg.found
                    && item_reg.lo < item_reg.hi1;

    always_comb
    begin
        out_item       = item_reg;
        out_item.valid = valid_reg;
        if (active)
        begin
            if (item_reg.key == probe)
            begin
                out_item.found = 1'b1;
                out_item.match = mid_reg;
            end
            else if (item_reg.key > probe)
                out_item.lo = {1'b0, mid_reg} + stbs_pkg::CNT_W'(1);
            else
                out_item.hi1 = {1'b0, mid_reg};
        end
    end

endmodule

// File: src/sorted_table_binary_search.sv
// Sorted key table with case-insensitive binary search. Takes one item per
// clock (busy stays low): a write stores key_word at entry_index and gives no
// result; a search gives found/match_index on done for one cycle, once the
// item has passed seven probe stages, each holding its own copy of the table
// and doing one read and compare, and then the output register. done
// cannot be held off, so results must be taken when shown. Keys compare
// folded to lower case and cut at the first zero byte; searches cover
// entries below entry_count (clamped to 64) and must only reach entries
// already written. Write cfg_data with cfg_write only while no item is in
// flight.
module sorted_table_binary_search (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic                         action,
    input  logic [stbs_pkg::IDX_W-1:0]   entry_index,
    input  logic [stbs_pkg::KEY_W-1:0]   key_word,
    input  logic                         cfg_write,
    input  logic [stbs_pkg::CNT_W-1:0]   cfg_data,
    output logic                         done,
    output logic                         found,
    output logic [stbs_pkg::IDX_W-1:0]   match_index
);

    logic [stbs_pkg::CNT_W-1:0]  entry_count_reg;
    logic [stbs_pkg::CNT_W-1:0]  span;
    stbs_pkg::item_t             chain [stbs_pkg::PROBES+1];
    logic                        done_reg;
    logic                        found_reg;
    logic [stbs_pkg::IDX_W-1:0]  match_reg;

    // the pipeline never stalls
    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            entry_count_reg <= stbs_pkg::COUNT_RESET;
        else if (cfg_write)
            entry_count_reg <= cfg_data;
    end

    assign span = (entry_count_reg > stbs_pkg::COUNT_MAX) ? stbs_pkg::COUNT_MAX
                                                          : entry_count_reg;

    always_comb
    begin
        chain[0].valid  = start && !busy;
        chain[0].search = action;
        chain[0].idx    = entry_index;
        chain[0].key    = stbs_pkg::norm_key(key_word);
        chain[0].lo     = '0;
        chain[0].hi1    = span;
        chain[0].found  = 1'b0;
        chain[0].match  = '0;
    end

    for (genvar s = 0; s < stbs_pkg::PROBES; s++)
    begin : g_probe
        stbs_probe u_probe (
            .clk      (clk),
            .rst_n    (rst_n),
            .in_item  (chain[s]),
            .out_item (chain[s+1])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= chain[stbs_pkg::PROBES].valid
                        && chain[stbs_pkg::PROBES].search == stbs_pkg::ACT_SEARCH;
    end

    always_ff @(posedge clk)
    begin
        found_reg <= chain[stbs_pkg::PROBES].found;
        match_reg <= chain[stbs_pkg::PROBES].match;
    end

    assign done        = done_reg;
    assign found       = found_reg;
    assign match_index = match_reg;

    a_done_from_search: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy && action == stbs_pkg::ACT_SEARCH, stbs_pkg::LATENCY))
        else $error("result without a search item");

    a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && action == stbs_pkg::ACT_WRITE |-> ##8 !done)
        else $error("write item produced a result");

    a_miss_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && !found |-> match_index == '0)
        else $error("miss with non-zero index");

endmodule
